[rtl/core/plst_pkg.sv]
// ----------------------------------------------------------------------------
// plst_pkg
// Shared types and codes of the positional list engine: operation and
// status codes, cell chain commands and the fixed field widths.
// ----------------------------------------------------------------------------
package plst_pkg;

  // default geometry
  localparam int PLST_CAPACITY   = 16;
  localparam int PLST_DATA_WIDTH = 32;

  // fixed field widths of the request and result words
  localparam int OP_W     = 3;
  localparam int VALUE_W  = 32;
  localparam int POS_W    = 8;
  localparam int STATUS_W = 2;
  localparam int ECOUNT_W = 5;
  localparam int ELEM_W   = 32;

  // cell index width, sized for the largest supported capacity
  localparam int IDX_W = 6;

  // request operation codes
  localparam logic [OP_W-1:0] OP_INS_FIRST = 3'd0;
  localparam logic [OP_W-1:0] OP_INS_LAST  = 3'd1;
  localparam logic [OP_W-1:0] OP_DEL_FIRST = 3'd2;
  localparam logic [OP_W-1:0] OP_DEL_LAST  = 3'd3;
  localparam logic [OP_W-1:0] OP_INS_AT    = 3'd4;
  localparam logic [OP_W-1:0] OP_DEL_AT    = 3'd5;
  localparam logic [OP_W-1:0] OP_DUMP      = 3'd6;

  // result status codes
  localparam logic [STATUS_W-1:0] STAT_OK     = 2'd0;
  localparam logic [STATUS_W-1:0] STAT_BADPOS = 2'd1;
  localparam logic [STATUS_W-1:0] STAT_EMPTY  = 2'd2;
  localparam logic [STATUS_W-1:0] STAT_FULL   = 2'd3;

  // cell chain commands
  typedef enum logic [1:0] {
    CMD_HOLD,
    CMD_INSERT,
    CMD_DELETE,
    CMD_ROTATE
  } cmd_kind_t;

  // command broadcast to every cell of the chain
  typedef struct packed {
    cmd_kind_t        kind;
    logic [IDX_W-1:0] idx;
  } cell_cmd_t;

endpackage

[rtl/core/plst_if.sv]
// ----------------------------------------------------------------------------
// plst_in_if / plst_out_if
// Valid/ready channels of the positional list engine: request words in,
// result words out.
// ----------------------------------------------------------------------------
interface plst_in_if import plst_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic [OP_W-1:0]           operation;
  logic signed [VALUE_W-1:0] value;
  logic [POS_W-1:0]          position;

  modport source (output valid, output operation, output value, output position,
                  input ready);
  modport sink   (input valid, input operation, input value, input position,
                  output ready);
endinterface

interface plst_out_if import plst_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic [STATUS_W-1:0]      status;
  logic [ECOUNT_W-1:0]      element_count;
  logic signed [ELEM_W-1:0] element;
  logic                     last;

  modport source (output valid, output status, output element_count, output element,
                  output last, input ready);
  modport sink   (input valid, input status, input element_count, input element,
                  input last, output ready);
endinterface

[rtl/core/plst_cell.sv]
// ----------------------------------------------------------------------------
// plst_cell
// One storage cell of the list chain. Holds one entry and on each command
// keeps it, takes a neighbor's entry or loads the broadcast data word.
// ----------------------------------------------------------------------------
module plst_cell import plst_pkg::*; #(
  parameter int DATA_WIDTH = PLST_DATA_WIDTH,
  parameter int INDEX      = 0
) (
  input  logic                  clk,
  input  cell_cmd_t             cmd,
  input  logic [DATA_WIDTH-1:0] load_data,
  input  logic [DATA_WIDTH-1:0] left_data,
  input  logic [DATA_WIDTH-1:0] right_data,
  output logic [DATA_WIDTH-1:0] data_q
);

  localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(INDEX);

  logic [DATA_WIDTH-1:0] data_r;
  logic [DATA_WIDTH-1:0] data_nxt;

  // select the next entry from the command and this cell's place
  always_comb begin
    data_nxt = data_r;
    unique case (cmd.kind)
      CMD_INSERT: begin
        // entries at and after the slot move up one place
        if (MY_IDX == cmd.idx) begin
          data_nxt = load_data;
        end else if (MY_IDX > cmd.idx) begin
          data_nxt = left_data;
        end
      end
      CMD_DELETE: begin
        // entries at and after the slot close the gap
        if (MY_IDX >= cmd.idx) begin
          data_nxt = right_data;
        end
      end
      CMD_ROTATE: begin
        // used entries turn by one, the head wraps to the tail
        if (MY_IDX == cmd.idx) begin
          data_nxt = load_data;
        end else if (MY_IDX < cmd.idx) begin
          data_nxt = right_data;
        end
      end
      CMD_HOLD: begin
        data_nxt = data_r;
      end
    endcase
  end

  // entry storage, undefined until written
  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  assign data_q = data_r;

endmodule

[rtl/core/positional_list_engine_core.sv]
// ----------------------------------------------------------------------------
// positional_list_engine_core
// Bounded ordered list with insert and delete at front, back or a one-based
// position, and an in-order dump, built as a chain of shifting cells.
// ----------------------------------------------------------------------------
// Every insert or delete shifts all cells by one place in parallel, so such
// requests are accepted one per cycle while the result word is taken. A dump
// takes the request, then sends one word per cycle while the output is free,
// read from the head cell while the used part of the chain rotates by one
// place, which leaves the list in its original order after the last word. A
// dump of an empty list returns a single word like any other request.
// Entries are not cleared at reset; only the state, element count, dump
// counter and output valid are.
// ----------------------------------------------------------------------------
module positional_list_engine_core import plst_pkg::*; #(
  parameter int CAPACITY   = PLST_CAPACITY,
  parameter int DATA_WIDTH = PLST_DATA_WIDTH
) (
  input  logic       clk,
  input  logic       rst_n,
  plst_in_if.sink    in_if,
  plst_out_if.source out_if
);

  localparam int CW   = $clog2(CAPACITY + 1);
  localparam int CMPW = ((CW > POS_W) ? CW : POS_W) + 1;

  // control states
  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_DUMP = 1'b1;

  logic                  state_r, state_nxt;
  logic [CW-1:0]         count_r, count_nxt;
  logic [CW-1:0]         dump_left_r, dump_left_nxt;

  logic                  out_valid_r, out_valid_nxt;
  logic [STATUS_W-1:0]   out_status_r, out_status_nxt;
  logic [ECOUNT_W-1:0]   out_count_r, out_count_nxt;
  logic [ELEM_W-1:0]     out_element_r, out_element_nxt;
  logic                  out_last_r, out_last_nxt;

  logic                  out_free;
  logic                  in_fire;
  logic                  is_empty;
  logic                  is_full;
  logic [CMPW-1:0]       pos_ext;
  logic [CMPW-1:0]       cnt_ext;
  logic [63:0]           value_ext;
  logic [63:0]           head_ext;
  logic                  load_head;
  logic [DATA_WIDTH-1:0] load_data;
  cell_cmd_t             cmd;

  logic [DATA_WIDTH-1:0] cell_q [CAPACITY];

  // handshake
  assign out_free    = !out_valid_r || out_if.ready;
  assign in_if.ready = (state_r == ST_IDLE) && out_free;
  assign in_fire     = in_if.valid && in_if.ready;

  // operand preparation
  assign is_empty  = (count_r == '0);
  assign is_full   = (count_r == CW'(CAPACITY));
  assign pos_ext   = CMPW'(in_if.position);
  assign cnt_ext   = CMPW'(count_r);
  assign value_ext = 64'($unsigned(in_if.value));
  assign head_ext  = 64'(cell_q[0]);
  assign load_data = load_head ? cell_q[0] : value_ext[DATA_WIDTH-1:0];

  // request decode, dump sequencing and result word
  always_comb begin
    state_nxt       = state_r;
    count_nxt       = count_r;
    dump_left_nxt   = dump_left_r;
    cmd             = '{kind: CMD_HOLD, idx: '0};
    load_head       = 1'b0;
    out_valid_nxt   = out_valid_r && !out_if.ready;
    out_status_nxt  = out_status_r;
    out_count_nxt   = out_count_r;
    out_element_nxt = out_element_r;
    out_last_nxt    = out_last_r;

    if (in_fire) begin
      out_valid_nxt   = 1'b1;
      out_status_nxt  = STAT_OK;
      out_element_nxt = '0;
      out_last_nxt    = 1'b1;
      unique case (in_if.operation)
        OP_INS_FIRST, OP_INS_LAST: begin
          if (is_full) begin
            out_status_nxt = STAT_FULL;
          end else begin
            cmd.kind  = CMD_INSERT;
            cmd.idx   = (in_if.operation == OP_INS_FIRST) ? '0 : IDX_W'(count_r);
            count_nxt = count_r + 1'b1;
          end
        end
        OP_DEL_FIRST, OP_DEL_LAST: begin
          if (is_empty) begin
            out_status_nxt = STAT_EMPTY;
          end else begin
            cmd.kind  = CMD_DELETE;
            cmd.idx   = (in_if.operation == OP_DEL_FIRST) ? '0 : IDX_W'(count_r - 1'b1);
            count_nxt = count_r - 1'b1;
          end
        end
        OP_INS_AT: begin
          if (pos_ext == '0 || pos_ext > cnt_ext + 1'b1) begin
            out_status_nxt = STAT_BADPOS;
          end else if (is_full) begin
            out_status_nxt = STAT_FULL;
          end else begin
            cmd.kind  = CMD_INSERT;
            cmd.idx   = IDX_W'(pos_ext - 1'b1);
            count_nxt = count_r + 1'b1;
          end
        end
        OP_DEL_AT: begin
          if (is_empty) begin
            out_status_nxt = STAT_EMPTY;
          end else if (pos_ext == '0 || pos_ext > cnt_ext) begin
            out_status_nxt = STAT_BADPOS;
          end else begin
            cmd.kind  = CMD_DELETE;
            cmd.idx   = IDX_W'(pos_ext - 1'b1);
            count_nxt = count_r - 1'b1;
          end
        end
        OP_DUMP: begin
          if (is_empty) begin
            out_status_nxt = STAT_EMPTY;
          end else begin
            // words follow from the dump state
            out_valid_nxt = out_valid_r && !out_if.ready;
            state_nxt     = ST_DUMP;
            dump_left_nxt = count_r;
          end
        end
        default: begin
          out_status_nxt = STAT_OK;
        end
      endcase
      out_count_nxt = ECOUNT_W'(count_nxt);
    end else if (state_r == ST_DUMP && out_free) begin
      // emit the head entry and rotate the used cells by one
      cmd.kind        = CMD_ROTATE;
      cmd.idx         = IDX_W'(count_r - 1'b1);
      load_head       = 1'b1;
      out_valid_nxt   = 1'b1;
      out_status_nxt  = STAT_OK;
      out_count_nxt   = ECOUNT_W'(count_r);
      out_element_nxt = head_ext[ELEM_W-1:0];
      out_last_nxt    = (dump_left_r == CW'(1));
      dump_left_nxt   = dump_left_r - 1'b1;
      if (dump_left_r == CW'(1)) begin
        state_nxt = ST_IDLE;
      end
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      dump_left_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      dump_left_r <= dump_left_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // result word payload
  always_ff @(posedge clk) begin
    out_status_r  <= out_status_nxt;
    out_count_r   <= out_count_nxt;
    out_element_r <= out_element_nxt;
    out_last_r    <= out_last_nxt;
  end

  assign out_if.valid         = out_valid_r;
  assign out_if.status        = out_status_r;
  assign out_if.element_count = out_count_r;
  assign out_if.element       = out_element_r;
  assign out_if.last          = out_last_r;

  // cell chain, ends fed back on themselves
  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    plst_cell #(
      .DATA_WIDTH (DATA_WIDTH),
      .INDEX      (g)
    ) u_cell (
      .clk        (clk),
      .cmd        (cmd),
      .load_data  (load_data),
      .left_data  (cell_q[(g == 0) ? g : g - 1]),
      .right_data (cell_q[(g == CAPACITY - 1) ? g : g + 1]),
      .data_q     (cell_q[g])
    );
  end

  // count never exceeds the capacity
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(CAPACITY))
    else $error("element count above capacity");

  // a dump in progress always has words left to send
  a_dump_left: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_DUMP |-> dump_left_r != '0 && dump_left_r <= count_r)
    else $error("dump counter out of range");

  // a non-dump request yields a result word in the next cycle
  a_single_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && in_if.operation != OP_DUMP |=> out_valid_r && out_last_r)
    else $error("request produced no result word");

  // the element count stays unchanged while a dump is in progress
  a_dump_no_edit: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_DUMP |=> $stable(count_r))
    else $error("element count changed during dump");

endmodule
